/* rtl/eds_pkg.sv */
// Shared constants and controller/datapath handoff types for the Euclidean distance stream.
package eds_pkg;

  localparam int FIELD_W    = 16;
  localparam int SUM_W      = 44;
  localparam int COUNT_W    = 13;
  localparam int DIST_W     = 30;
  localparam int FRAC_W     = 8;
  localparam int COUNT_MAX  = (1 << COUNT_W) - 1;
  localparam int ROOT_STEPS = DIST_W;
  localparam int ITER_W     = $clog2(ROOT_STEPS);
  localparam int RAD_W      = SUM_W + 2 * FRAC_W;
  localparam int REM_W      = DIST_W + 2;

  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [DIST_W-1:0]  dist_t;

  typedef struct packed {
    logic take;
    logic root_load;
    logic root_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last_done;
    logic out_free;
  } status_t;

endpackage

/* rtl/eds_in_if.sv */
// Input channel: one element pair per item.
interface eds_in_if;
  import eds_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] element_a;
  logic [FIELD_W-1:0] element_b;
  logic               last_element;

  modport source (output valid, element_a, element_b, last_element, input ready);
  modport sink   (input valid, element_a, element_b, last_element, output ready);
endinterface

/* rtl/eds_out_if.sv */
// Output channel: one distance result per vector.
interface eds_out_if;
  import eds_pkg::*;

  logic   valid;
  logic   ready;
  dist_t  distance;
  sum_t   sum_squares;
  count_t element_count;
  logic   overflow;

  modport source (output valid, distance, sum_squares, element_count, overflow, input ready);
  modport sink   (input valid, distance, sum_squares, element_count, overflow, output ready);
endinterface

/* rtl/eds_ctrl.sv */
// Controller state machine: accumulate, drain, square root iterations, result load.
module eds_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  eds_pkg::status_t status_i,
  output eds_pkg::cmd_t    cmd_o
);
  import eds_pkg::*;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_DRAIN,
    ST_LOAD,
    ST_ROOT,
    ST_FINISH
  } state_e;

  state_e                  state_q, state_d;
  logic   [ITER_W-1:0]     iter_q, iter_d;
  logic                    take;

  assign in_ready_o = (state_q == ST_RUN);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    state_d           = state_q;
    iter_d            = iter_q;
    cmd_o             = '0;
    cmd_o.take        = take;
    unique case (state_q)
      ST_RUN: begin
        if (take && in_last_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status_i.last_done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.root_load = 1'b1;
        iter_d          = ITER_W'(ROOT_STEPS - 1);
        state_d         = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        iter_d          = iter_q - 1'b1;
        if (iter_q == '0) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && in_last_i) |=> !in_ready_o)
    else $error("input still ready after last item");

  a_load_to_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.root_load |=> (state_q == ST_ROOT && iter_q == ITER_W'(ROOT_STEPS - 1)))
    else $error("root iteration did not start after load");

  a_out_only_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (state_q == ST_FINISH && status_i.out_free))
    else $error("result loaded outside finish");

endmodule

/* rtl/eds_datapath.sv */
// Datapath: difference, square, saturating sum, pair count, restoring square root, result register.
module eds_datapath #(
  parameter int MAX_LENGTH   = 4096,
  parameter int ELEMENT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [eds_pkg::FIELD_W-1:0]   element_a_i,
  input  logic [eds_pkg::FIELD_W-1:0]   element_b_i,
  input  logic                          last_element_i,
  input  eds_pkg::cmd_t                 cmd_i,
  output eds_pkg::status_t              status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output eds_pkg::dist_t                distance_o,
  output eds_pkg::sum_t                 sum_squares_o,
  output eds_pkg::count_t               element_count_o,
  output logic                          overflow_o
);
  import eds_pkg::*;

  localparam int EB    = ELEMENT_BITS;
  localparam int XW    = (EB > FIELD_W) ? EB : FIELD_W;
  localparam int SQ_W  = 2 * EB;
  localparam int ADD_W = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;
  localparam int CAP   = (MAX_LENGTH < COUNT_MAX) ? MAX_LENGTH : COUNT_MAX;
  localparam logic [ADD_W-1:0] SUM_MAX_X = ADD_W'({SUM_W{1'b1}});

  logic [XW-1:0]        a_x, b_x;
  logic signed [EB:0]   a_s, b_s, diff_s;
  logic [EB:0]          diff_abs;
  logic                 at_cap;

  logic [EB-1:0]        diff_q;
  logic                 v1_q, last1_q, force1_q;
  logic [SQ_W-1:0]      sq_q;
  logic                 v2_q, last2_q, force2_q;

  sum_t                 sum_q, sum_d;
  count_t               count_q;
  logic                 ovf_q;
  logic [ADD_W-1:0]     total;

  logic [RAD_W-1:0]     rad_q;
  logic [REM_W-1:0]     rem_q;
  dist_t                root_q;
  logic [REM_W+1:0]     rem_sh, trial;

  logic                 out_valid_q;
  dist_t                dist_q;
  sum_t                 osum_q;
  count_t               ocount_q;
  logic                 oovf_q;

  assign a_x      = XW'($unsigned(element_a_i));
  assign b_x      = XW'($unsigned(element_b_i));
  assign a_s      = $signed({a_x[EB-1], a_x[EB-1:0]});
  assign b_s      = $signed({b_x[EB-1], b_x[EB-1:0]});
  assign diff_s   = a_s - b_s;
  assign diff_abs = diff_s[EB] ? (EB + 1)'(0) - diff_s : diff_s;
  assign at_cap   = (count_q >= COUNT_W'(CAP));

  assign total = ADD_W'(sum_q) + ADD_W'(sq_q);
  always_comb begin
    sum_d = sum_q;
    if (cmd_i.out_load) begin
      sum_d = '0;
    end else if (v2_q) begin
      if (force2_q || total > SUM_MAX_X) begin
        sum_d = {SUM_W{1'b1}};
      end else begin
        sum_d = total[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      sum_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      v1_q  <= cmd_i.take;
      v2_q  <= v1_q;
      sum_q <= sum_d;
      if (cmd_i.out_load) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.take) begin
        if (at_cap) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      diff_q   <= diff_abs[EB-1:0];
      last1_q  <= last_element_i;
      force1_q <= at_cap;
    end
    sq_q     <= diff_q * diff_q;
    last2_q  <= last1_q;
    force2_q <= force1_q;
  end

  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root_q, 2'b01});

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_load) begin
      rad_q  <= {sum_q, {(2 * FRAC_W){1'b0}}};
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= REM_W'(rem_sh - trial);
        root_q <= {root_q[DIST_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[REM_W-1:0];
        root_q <= {root_q[DIST_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      dist_q   <= root_q;
      osum_q   <= sum_q;
      ocount_q <= count_q;
      oovf_q   <= ovf_q;
    end
  end

  assign status_o.last_done = v2_q && last2_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign distance_o      = dist_q;
  assign sum_squares_o   = osum_q;
  assign element_count_o = ocount_q;
  assign overflow_o      = oovf_q;

  a_count_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(CAP))
    else $error("pair count above cap");

  a_ovf_at_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == COUNT_W'(CAP)))
    else $error("overflow without full count");

  a_ovf_forces_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && force2_q && !cmd_i.out_load) |=> (sum_q == {SUM_W{1'b1}}))
    else $error("overflowed pair did not saturate sum");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("result load lost");

endmodule

/* rtl/euclidean_distance_stream.sv */
// Top level of the streaming Euclidean distance block.
//
//   channel  dir  payload                                          role
//   in_i     in   element_a, element_b, last_element               one element pair
//   out_o    out  distance, sum_squares, element_count, overflow   one result per vector
//
// Pairs are taken one per cycle, only in the run state, through a three-stage difference,
// square and sum pipeline. After the last pair, input is held low while the pipeline drains,
// during the root load, the 30 square root steps (one result bit each) and the result load.
// The result sits in an output register; a new vector starts while it waits.
// A stalled output holds the block only when the next result is ready to load.
// Reset clears the sum, count, overflow flag and all valid bits.
module euclidean_distance_stream #(
  parameter int MAX_LENGTH   = 4096,
  parameter int ELEMENT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  eds_in_if.sink     in_i,
  eds_out_if.source  out_o
);
  import eds_pkg::*;

  cmd_t    cmd;
  status_t status;

  eds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_element),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  eds_datapath #(
    .MAX_LENGTH   (MAX_LENGTH),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .element_a_i     (in_i.element_a),
    .element_b_i     (in_i.element_b),
    .last_element_i  (in_i.last_element),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .distance_o      (out_o.distance),
    .sum_squares_o   (out_o.sum_squares),
    .element_count_o (out_o.element_count),
    .overflow_o      (out_o.overflow)
  );

endmodule
